@@ hdl/aesctr_pkg.sv @@
`timescale 1ns / 1ps
package aesctr_pkg;

	localparam int BlockBits = 128;
	localparam int CountBits = 5;
	localparam int NumRounds = 10;
	localparam logic [CountBits-1:0] MaxCount = 5'd16;

	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1,
		REG_IV_HIGH  = 2'd2,
		REG_IV_LOW   = 2'd3
	} reg_index_t;

	// one beat as it travels down the round chain
	typedef struct packed {
		logic [BlockBits-1:0] state;
		logic [BlockBits-1:0] rkey;
		logic [BlockBits-1:0] data;
		logic [CountBits-1:0] cnt;
	} beat_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [NumRounds+1] = '{
		8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// byte i of a block sits in the top bits for i = 0
	function automatic logic [7:0] get_byte(logic [BlockBits-1:0] b, int i);
		return b[BlockBits-1-8*i -: 8];
	endfunction

	function automatic logic [7:0] gf_double(logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [BlockBits-1:0] sub_shift(logic [BlockBits-1:0] s);
		logic [BlockBits-1:0] t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[BlockBits-1-8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
			end
		end
		return t;
	endfunction

	function automatic logic [BlockBits-1:0] mix_columns(logic [BlockBits-1:0] s);
		logic [BlockBits-1:0] t;
		logic [7:0] a0, a1, a2, a3, h;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			h  = a0 ^ a1 ^ a2 ^ a3;
			t[BlockBits-1-8*(4*c)   -: 8] = a0 ^ h ^ gf_double(a0 ^ a1);
			t[BlockBits-1-8*(4*c+1) -: 8] = a1 ^ h ^ gf_double(a1 ^ a2);
			t[BlockBits-1-8*(4*c+2) -: 8] = a2 ^ h ^ gf_double(a2 ^ a3);
			t[BlockBits-1-8*(4*c+3) -: 8] = a3 ^ h ^ gf_double(a3 ^ a0);
		end
		return t;
	endfunction

	// next round key from the previous one
	function automatic logic [BlockBits-1:0] next_key(logic [BlockBits-1:0] k,
		logic [7:0] rc);
		logic [31:0] t, w0, w1, w2, w3;
		t  = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
			SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [BlockBits-1:0] lead_mask(logic [CountBits-1:0] n);
		logic [BlockBits-1:0] m;
		for (int i = 0; i < 16; i++) begin
			m[BlockBits-1-8*i -: 8] = (CountBits'(i) < n) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

endpackage

@@ hdl/aesctr_round.sv @@
`timescale 1ns / 1ps
module aesctr_round import aesctr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  beat_t      up_beat,
	input  logic [7:0] rcon,
	input  logic       last,
	output logic       dn_valid,
	input  logic       dn_ready,
	output beat_t      dn_beat
);

	logic                 valid_q;
	beat_t                beat_q;
	logic [BlockBits-1:0] key_nx;
	logic [BlockBits-1:0] ss;

	assign up_ready = !valid_q || dn_ready;
	assign key_nx   = next_key(up_beat.rkey, rcon);
	assign ss       = sub_shift(up_beat.state);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			beat_q.state <= (last ? ss : mix_columns(ss)) ^ key_nx;
			beat_q.rkey  <= key_nx;
			beat_q.data  <= up_beat.data;
			beat_q.cnt   <= up_beat.cnt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_beat  = beat_q;

endmodule

@@ hdl/aes128_ctr_cipher.sv @@
`timescale 1ns / 1ps
// aes-128 counter mode: each input beat carries 16 data bytes and a count of
// leading valid bytes; the block encrypts the current 128-bit big-endian
// counter and xors the keystream into the data, zeroing bytes at or past the
// count (counts above 16 act as 16). the counter steps by one per beat,
// wrapping at 2^128, and a beat with restart set first reloads it from the iv
// registers. one stage does the initial key add and counter select, then ten
// round cells each do one aes round (the last without mixcolumns) and expand
// their own round key from the neighbor's; the last is the output stage.
// throughput is one beat per cycle unless stalled; every cell has its own
// ready, so bubbles collapse and the input keeps flowing while a finished
// beat waits at the output, until the chain fills. configuration writes are
// accepted every cycle and must only be issued while no beat is in flight.
module aes128_ctr_cipher import aesctr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [63:0]          data_in_high,
	input  logic [63:0]          data_in_low,
	input  logic [CountBits-1:0] valid_bytes,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          data_out_high,
	output logic [63:0]          data_out_low,
	output logic [CountBits-1:0] out_count
);

	logic [BlockBits-1:0] key_q;
	logic [BlockBits-1:0] iv_q;
	logic [BlockBits-1:0] ctr_q;
	logic [BlockBits-1:0] ctr_use;

	logic  v_s0;
	beat_t b_s0;
	logic  rdy_s0;

	logic  cell_valid [NumRounds+1];
	logic  cell_ready [NumRounds+1];
	beat_t cell_beat  [NumRounds+1];

	logic [BlockBits-1:0] ks_out;

	// config registers, no readback
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv_q  <= '0;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_KEY_HIGH: key_q[127:64] <= cfg_data;
				REG_KEY_LOW:  key_q[63:0]   <= cfg_data;
				REG_IV_HIGH:  iv_q[127:64]  <= cfg_data;
				REG_IV_LOW:   iv_q[63:0]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// counter for this beat, stepped on every accepted beat
	assign ctr_use = restart ? iv_q : ctr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (in_valid && in_ready) begin
			ctr_q <= ctr_use + BlockBits'(1);
		end
	end

	// entry stage: initial round key add, count clamp
	assign rdy_s0   = !v_s0 || cell_ready[1];
	assign in_ready = rdy_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (rdy_s0) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s0) begin
			b_s0.state <= ctr_use ^ key_q;
			b_s0.rkey  <= key_q;
			b_s0.data  <= {data_in_high, data_in_low};
			b_s0.cnt   <= (valid_bytes > MaxCount) ? MaxCount : valid_bytes;
		end
	end

	assign cell_valid[0] = v_s0;
	assign cell_beat[0]  = b_s0;
	assign cell_ready[0] = rdy_s0;

	// row of round cells
	for (genvar r = 1; r <= NumRounds; r++) begin : g_round
		aesctr_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cell_valid[r-1]),
			.up_ready (cell_ready[r]),
			.up_beat  (cell_beat[r-1]),
			.rcon     (RCON[r]),
			.last     (r == NumRounds),
			.dn_valid (cell_valid[r]),
			.dn_ready ((r == NumRounds) ? out_ready : cell_ready[r+1 > NumRounds ? NumRounds : r+1]),
			.dn_beat  (cell_beat[r])
		);
	end

	// keystream xor and tail masking on the held output beat
	assign ks_out        = (cell_beat[NumRounds].data ^ cell_beat[NumRounds].state)
		& lead_mask(cell_beat[NumRounds].cnt);
	assign out_valid     = cell_valid[NumRounds];
	assign data_out_high = ks_out[127:64];
	assign data_out_low  = ks_out[63:0];
	assign out_count     = cell_beat[NumRounds].cnt;

endmodule

@@ hdl/aesctr_checker.sv @@
`timescale 1ns / 1ps
module aesctr_checker import aesctr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [63:0]          data_out_high,
	input logic [63:0]          data_out_low,
	input logic [CountBits-1:0] out_count
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out_high)
		&& $stable(data_out_low) && $stable(out_count))
		else $error("output beat changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_count <= MaxCount)
		else $error("count above sixteen");

	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_count <= 5'd8 |-> data_out_low == 64'd0)
		else $error("low half not masked");

	a_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_count == 5'd0 |-> data_out_high == 64'd0)
		else $error("high half not masked");

endmodule

bind aes128_ctr_cipher aesctr_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.data_out_high (data_out_high),
	.data_out_low  (data_out_low),
	.out_count     (out_count)
);
